/* rtl/vttr_pkg.sv */
// Package for the vertex twist, taper and roll unit.
// Holds fixed-point widths, the CORDIC angle table and shared helpers.
// Depends on nothing; vttr_cordic and the top level import it.
package vttr_pkg;

    localparam int TRIG_ITERATIONS = 16;
    localparam int ATAN_COUNT      = 24;
    localparam int CORDIC_STEPS    = (TRIG_ITERATIONS > ATAN_COUNT) ? ATAN_COUNT
                                                                    : TRIG_ITERATIONS;
    localparam int CW              = 34;

    localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [31:0]   ONE_Q27     = 32'sd134217728;

    localparam logic [1:0] REG_TWIST_RATE  = 2'd0;
    localparam logic [1:0] REG_CONVERGENCE = 2'd1;
    localparam logic [1:0] REG_ROLL_RATE   = 2'd2;

    typedef logic signed [CW-1:0] cval_t;

    typedef struct packed {
        logic signed [33:0] r;
        logic signed [15:0] ct;
    } side_t;

    function automatic logic [31:0] atan_turn(input int idx);
        logic [31:0] t;
        case (idx)
            0:  t = 32'h20000000;
            1:  t = 32'h12E4051D;
            2:  t = 32'h09FB385B;
            3:  t = 32'h051111D4;
            4:  t = 32'h028B0D43;
            5:  t = 32'h0145D7E1;
            6:  t = 32'h00A2F61E;
            7:  t = 32'h00517C55;
            8:  t = 32'h0028BE53;
            9:  t = 32'h00145F2E;
            10: t = 32'h000A2F98;
            11: t = 32'h000517CC;
            12: t = 32'h00028BE6;
            13: t = 32'h000145F3;
            14: t = 32'h0000A2F9;
            15: t = 32'h0000517C;
            16: t = 32'h000028BE;
            17: t = 32'h0000145F;
            18: t = 32'h00000A2F;
            19: t = 32'h00000517;
            20: t = 32'h0000028B;
            21: t = 32'h00000145;
            22: t = 32'h000000A2;
            23: t = 32'h00000051;
            default: t = 32'h00000000;
        endcase
        return t;
    endfunction

    function automatic logic [31:0] sat32(input logic signed [69:0] v);
        logic [31:0] s;
        if (v > 70'sd2147483647)
            s = 32'h7FFFFFFF;
        else if (v < -70'sd2147483648)
            s = 32'h80000000;
        else
            s = v[31:0];
        return s;
    endfunction

endpackage

/* rtl/vttr_cordic.sv */
// Dual-lane pipelined CORDIC: cosine and sine in Q.30 of two 32-bit turn angles.
// One register stage for quarter-turn reduction, one per step, one for the output.
// Depends on vttr_pkg.
module vttr_cordic (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [31:0]            in_ang_a,
    input  logic [31:0]            in_ang_b,
    input  vttr_pkg::side_t        in_side,
    output logic                   out_valid,
    input  logic                   out_ready,
    output vttr_pkg::cval_t        out_cos_a,
    output vttr_pkg::cval_t        out_sin_a,
    output vttr_pkg::cval_t        out_cos_b,
    output vttr_pkg::cval_t        out_sin_b,
    output vttr_pkg::side_t        out_side
);
    import vttr_pkg::*;

    localparam int NS = CORDIC_STEPS;

    cval_t       x_reg [0:NS][0:1];
    cval_t       y_reg [0:NS][0:1];
    cval_t       z_reg [0:NS][0:1];
    logic [1:0]  q_reg [0:NS][0:1];
    side_t       side_reg [0:NS];
    logic        v_reg [0:NS];
    logic        rdy [0:NS+1];

    logic        vo_reg;
    cval_t       co_reg [0:1];
    cval_t       so_reg [0:1];
    side_t       sideo_reg;

    logic [31:0] ang_in [0:1];

    assign ang_in[0] = in_ang_a;
    assign ang_in[1] = in_ang_b;

    assign rdy[NS+1] = !vo_reg || out_ready;
    assign in_ready  = rdy[0];

    genvar i, l;
    generate
        for (i = 0; i <= NS; i++) begin : g_rdy
            assign rdy[i] = !v_reg[i] || rdy[i+1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[0] <= 1'b0;
            else if (rdy[0])
                v_reg[0] <= in_valid;
        end

        always_ff @(posedge clk)
        begin
            if (rdy[0])
                side_reg[0] <= in_side;
        end

        for (l = 0; l < 2; l++) begin : g_red
            logic [31:0] ang_plus;
            logic [1:0]  quad;
            logic [31:0] red;
            assign ang_plus = ang_in[l] + 32'h20000000;
            assign quad     = ang_plus[31:30];
            assign red      = ang_in[l] - {quad, 30'd0};
            always_ff @(posedge clk)
            begin
                if (rdy[0])
                begin
                    x_reg[0][l] <= CORDIC_GAIN;
                    y_reg[0][l] <= '0;
                    z_reg[0][l] <= CW'($signed(red));
                    q_reg[0][l] <= quad;
                end
            end
        end

        for (i = 0; i < NS; i++) begin : g_step
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    v_reg[i+1] <= 1'b0;
                else if (rdy[i+1])
                    v_reg[i+1] <= v_reg[i];
            end

            always_ff @(posedge clk)
            begin
                if (rdy[i+1])
                    side_reg[i+1] <= side_reg[i];
            end

            for (l = 0; l < 2; l++) begin : g_lane
                cval_t dx, dy, at;
                assign dx = y_reg[i][l] >>> i;
                assign dy = x_reg[i][l] >>> i;
                assign at = CW'($signed({1'b0, atan_turn(i)}));
                always_ff @(posedge clk)
                begin
                    if (rdy[i+1])
                    begin
                        q_reg[i+1][l] <= q_reg[i][l];
                        if (!z_reg[i][l][CW-1])
                        begin
                            x_reg[i+1][l] <= x_reg[i][l] - dx;
                            y_reg[i+1][l] <= y_reg[i][l] + dy;
                            z_reg[i+1][l] <= z_reg[i][l] - at;
                        end
                        else
                        begin
                            x_reg[i+1][l] <= x_reg[i][l] + dx;
                            y_reg[i+1][l] <= y_reg[i][l] - dy;
                            z_reg[i+1][l] <= z_reg[i][l] + at;
                        end
                    end
                end
            end
        end

        for (l = 0; l < 2; l++) begin : g_out
            cval_t c_next, s_next;
            always_comb
            begin
                case (q_reg[NS][l])
                    2'd1:
                    begin
                        c_next = -y_reg[NS][l];
                        s_next = x_reg[NS][l];
                    end
                    2'd2:
                    begin
                        c_next = -x_reg[NS][l];
                        s_next = -y_reg[NS][l];
                    end
                    2'd3:
                    begin
                        c_next = y_reg[NS][l];
                        s_next = -x_reg[NS][l];
                    end
                    default:
                    begin
                        c_next = x_reg[NS][l];
                        s_next = y_reg[NS][l];
                    end
                endcase
            end
            always_ff @(posedge clk)
            begin
                if (rdy[NS+1])
                begin
                    co_reg[l] <= c_next;
                    so_reg[l] <= s_next;
                end
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vo_reg <= 1'b0;
        else if (rdy[NS+1])
            vo_reg <= v_reg[NS];
    end

    always_ff @(posedge clk)
    begin
        if (rdy[NS+1])
            sideo_reg <= side_reg[NS];
    end

    assign out_valid = vo_reg;
    assign out_cos_a = co_reg[0];
    assign out_sin_a = so_reg[0];
    assign out_cos_b = co_reg[1];
    assign out_sin_b = so_reg[1];
    assign out_side  = sideo_reg;

endmodule

/* rtl/vertex_twist_taper_roll_unit.sv */
// Top level of the vertex twist, taper and roll unit.
// Depends on vttr_pkg and vttr_cordic.
//
// Usage: each input beat on s_axis carries one sphere sample (cos and sine of
// the polar angle in Q1.15, azimuth as a 16-bit turn fraction). Each output
// beat on m_axis carries the deformed vertex (x, y, z in Q16.15, saturated).
// The three rate registers are written through cfg_we, cfg_index and cfg_data;
// the user must write them only while the pipeline is empty, which the block
// does not enforce; an index past the last register is ignored. There are three
// input stages, the CORDIC pipeline with one stage per step plus two, and four
// multiply and rounding stages. One beat is accepted every cycle until full.
// Every stage holds a valid bit; a stage takes new data when it is empty or
// when the stage after it moves, so bubbles close up under a stall and
// s_axis_tready falls only when the whole pipeline is full.
// Reset clears all valid bits and sets the rate registers to zero.
module vertex_twist_taper_roll_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // cos_polar, sin_polar, azimuth
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [95:0] m_axis_tdata,   // pos_x, pos_y, pos_z
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import vttr_pkg::*;

    logic signed [15:0] twist_reg, conv_reg, roll_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            twist_reg <= '0;
            conv_reg  <= '0;
            roll_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_TWIST_RATE:  twist_reg <= cfg_data;
                REG_CONVERGENCE: conv_reg  <= cfg_data;
                REG_ROLL_RATE:   roll_reg  <= cfg_data;
                default:         ;
            endcase
        end
    end

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6, rdy7;
    logic c_in_ready, c_out_valid;

    assign rdy7 = !v7_reg || m_axis_tready;
    assign rdy6 = !v6_reg || rdy7;
    assign rdy5 = !v5_reg || rdy6;
    assign rdy4 = !v4_reg || rdy5;
    assign rdy3 = !v3_reg || c_in_ready;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;
    assign s_axis_tready = rdy1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end
        else
        begin
            if (rdy1) v1_reg <= s_axis_tvalid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= c_out_valid;
            if (rdy5) v5_reg <= v4_reg;
            if (rdy6) v6_reg <= v5_reg;
            if (rdy7) v7_reg <= v6_reg;
        end
    end

    // Stage 1: rate products.
    logic signed [15:0] ct1_reg, st1_reg;
    logic [15:0]        az1_reg;
    logic signed [31:0] tp1_reg, cp1_reg, rp1_reg;
    logic signed [15:0] ct_in, st_in;

    assign ct_in = s_axis_tdata[15:0];
    assign st_in = s_axis_tdata[31:16];

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            ct1_reg <= ct_in;
            st1_reg <= st_in;
            az1_reg <= s_axis_tdata[47:32];
            tp1_reg <= ct_in * twist_reg;
            cp1_reg <= ct_in * conv_reg;
            rp1_reg <= ct_in * roll_reg;
        end
    end

    // Stage 2: angles and scale.
    logic [31:0]        angt2_reg, angr2_reg;
    logic signed [31:0] scale2_reg;
    logic signed [15:0] ct2_reg, st2_reg;

    always_ff @(posedge clk)
    begin
        if (rdy2)
        begin
            angt2_reg  <= {az1_reg, 16'd0} + {tp1_reg[26:0], 5'd0};
            angr2_reg  <= {rp1_reg[26:0], 5'd0};
            scale2_reg <= ONE_Q27 + cp1_reg;
            ct2_reg    <= ct1_reg;
            st2_reg    <= st1_reg;
        end
    end

    // Stage 3: radius.
    logic signed [47:0] rprod;
    logic signed [47:0] rsum;
    logic signed [47:0] rshift;
    logic [31:0]        angt3_reg, angr3_reg;
    side_t              side3_reg;

    assign rprod  = scale2_reg * st2_reg;
    assign rsum   = rprod + 48'sd16384;
    assign rshift = rsum >>> 15;

    always_ff @(posedge clk)
    begin
        if (rdy3)
        begin
            angt3_reg    <= angt2_reg;
            angr3_reg    <= angr2_reg;
            side3_reg.r  <= rshift[33:0];
            side3_reg.ct <= ct2_reg;
        end
    end

    cval_t cw, sw, cr, sr;
    side_t c_side;

    vttr_cordic u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v3_reg),
        .in_ready  (c_in_ready),
        .in_ang_a  (angt3_reg),
        .in_ang_b  (angr3_reg),
        .in_side   (side3_reg),
        .out_valid (c_out_valid),
        .out_ready (rdy4),
        .out_cos_a (cw),
        .out_sin_a (sw),
        .out_cos_b (cr),
        .out_sin_b (sr),
        .out_side  (c_side)
    );

    // Stage 4: radius times twisted cosine and sine.
    logic signed [67:0] pc4_reg, ps4_reg;
    logic signed [15:0] ct4_reg;
    cval_t              cr4_reg, sr4_reg;

    always_ff @(posedge clk)
    begin
        if (rdy4)
        begin
            pc4_reg <= c_side.r * cw;
            ps4_reg <= c_side.r * sw;
            ct4_reg <= c_side.ct;
            cr4_reg <= cr;
            sr4_reg <= sr;
        end
    end

    // Stage 5: round y and z, shift x.
    logic signed [67:0] yr5, zr5;
    logic signed [33:0] y5_reg, x5_reg;
    logic [31:0]        z5_reg;
    cval_t              cr5_reg, sr5_reg;

    assign yr5 = (pc4_reg + (68'sd1 <<< 29)) >>> 30;
    assign zr5 = (ps4_reg + (68'sd1 <<< 41)) >>> 42;

    always_ff @(posedge clk)
    begin
        if (rdy5)
        begin
            y5_reg  <= yr5[33:0];
            z5_reg  <= sat32(70'(zr5));
            x5_reg  <= 34'(ct4_reg) <<< 12;
            cr5_reg <= cr4_reg;
            sr5_reg <= sr4_reg;
        end
    end

    // Stage 6: roll products.
    logic signed [67:0] xc6_reg, ys6_reg, xs6_reg, yc6_reg;
    logic [31:0]        z6_reg;

    always_ff @(posedge clk)
    begin
        if (rdy6)
        begin
            xc6_reg <= x5_reg * cr5_reg;
            ys6_reg <= y5_reg * sr5_reg;
            xs6_reg <= x5_reg * sr5_reg;
            yc6_reg <= y5_reg * cr5_reg;
            z6_reg  <= z5_reg;
        end
    end

    // Stage 7: roll sums, round and saturate.
    logic signed [69:0] sx7, sy7;
    logic [95:0]        out7_reg;

    assign sx7 = (70'(xc6_reg) - 70'(ys6_reg) + (70'sd1 <<< 41)) >>> 42;
    assign sy7 = (70'(xs6_reg) + 70'(yc6_reg) + (70'sd1 <<< 41)) >>> 42;

    always_ff @(posedge clk)
    begin
        if (rdy7)
            out7_reg <= {z6_reg, sat32(sy7), sat32(sx7)};
    end

    assign m_axis_tvalid = v7_reg;
    assign m_axis_tdata  = out7_reg;

endmodule

/* rtl/vttr_checker.sv */
// Port-level checker for the vertex twist, taper and roll unit.
// Depends on nothing but the top level's ports; bound to the top level below.
module vttr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [95:0] m_axis_tdata
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output beat changed while stalled");

    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled while output stage empty");

    a_flow_ready: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tready |-> s_axis_tready)
        else $error("input stalled while output drains");

    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> !m_axis_tvalid)
        else $error("output valid right after reset");

endmodule

bind vertex_twist_taper_roll_unit vttr_checker u_vttr_checker (.*);
